@@ design/vcrp_pkg.sv @@
`timescale 1ns / 1ps

package vcrp_pkg;

    // Sprite memory depth.
    localparam int SPRITE_MEM_DEPTH_DEF = 256;

    // Request codes.
    localparam logic [2:0] REQ_CPU_READ    = 3'd0;
    localparam logic [2:0] REQ_CPU_WRITE   = 3'd1;
    localparam logic [2:0] REQ_VBL_START   = 3'd2;
    localparam logic [2:0] REQ_VBL_END     = 3'd3;
    localparam logic [2:0] REQ_RENDER_STAT = 3'd4;

    // Register indexes.
    localparam logic [2:0] REG_CTRL0    = 3'd0;
    localparam logic [2:0] REG_CTRL1    = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Status bits and masks.
    localparam logic [7:0]  ST_VBLANK     = 8'h80;
    localparam logic [7:0]  ST_HIT        = 8'h40;
    localparam logic [7:0]  ST_OVER       = 8'h20;
    localparam logic [7:0]  LATCH_LOW     = 8'h1F;
    localparam logic [13:0] PALETTE_BASE  = 14'h3F00;
    localparam logic [5:0]  STEP_ACROSS   = 6'd1;
    localparam logic [5:0]  STEP_DOWN     = 6'd32;
    localparam logic [7:0]  OAM_BUSY_DATA = 8'hFF;

    // Input beat.
    typedef struct packed {
        logic [2:0] req_type;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic       rendering;
        logic [7:0] ext_read_data;
        logic [1:0] status_flags;
    } t_req_in;

    // Result beat.
    typedef struct packed {
        logic [7:0]  read_data;
        logic        mem_read;
        logic        mem_write;
        logic [13:0] mem_address;
        logic [7:0]  mem_write_data;
        logic        address_latched;
        logic [14:0] scroll_address;
        logic [2:0]  fine_x;
        logic [7:0]  control_zero;
        logic [7:0]  control_one;
        logic [7:0]  status_value;
    } t_req_out;

endpackage

@@ design/vcrp_oam.sv @@
`timescale 1ns / 1ps

// Sprite memory: one write port, one read port with registered data.
// The read register holds its value until the next read.
module vcrp_oam
    import vcrp_pkg::*;
#(
    parameter int DEPTH = SPRITE_MEM_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/video_chip_register_port_top.sv @@
`timescale 1ns / 1ps
// A result beat is offered in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless the output stalls; all register updates finish in the accept cycle.
// A sprite data read fetches from the sprite memory at accept and the memory's
// read register feeds the result beat and the bus latch from the next cycle on.
// Reset is synchronous and active low; it clears the port state and output flags
// but not the result data or the sprite memory, which is undefined until written.
module video_chip_register_port_top
    import vcrp_pkg::*;
#(
    parameter int SPRITE_MEM_DEPTH = SPRITE_MEM_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_req_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_req_out o_data
);

    localparam int AW = $clog2(SPRITE_MEM_DEPTH);

    logic [7:0]  r_sec;
    logic [7:0]  r_ctrl_a, n_ctrl_a;
    logic [7:0]  r_ctrl_b, n_ctrl_b;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_spr_addr, n_spr_addr;
    logic        r_toggle, n_toggle;
    logic [7:0]  r_bus_latch, n_bus_latch;
    logic        r_latch_mem, n_latch_mem;
    logic [7:0]  r_read_buf, n_read_buf;
    logic [5:0]  r_step, n_step;
    logic [14:0] r_refresh, n_refresh;
    logic [14:0] r_vaddr, n_vaddr;
    logic [2:0]  r_fine, n_fine;
    logic        r_out_valid;
    logic        r_out_mem, n_out_mem;
    t_req_out    r_out, n_out;

    logic        accept;
    logic [7:0]  spr_rdata;
    logic        spr_we, spr_re;
    logic [7:0]  latch_eff;
    logic [2:0]  widx;
    logic [7:0]  wd;
    logic [7:0]  status_bl;
    logic [14:0] vaddr_inc;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // The bus latch lives in the sprite read register after a sprite data read.
    assign latch_eff = r_latch_mem ? spr_rdata : r_bus_latch;
    assign vaddr_inc = r_vaddr + {9'd0, r_step};

    // Protected chips swap the two control registers on writes.
    assign widx = (r_sec != 8'd0 && i_data.reg_index[2:1] == 2'b00)
                ? (i_data.reg_index ^ 3'd1) : i_data.reg_index;
    assign wd   = (widx == REG_OAM_DATA && i_data.rendering) ? OAM_BUSY_DATA
                : i_data.write_data;
    assign status_bl = (r_sec != 8'd0) ? ((r_status & (ST_VBLANK | ST_HIT)) | r_sec)
                     : (r_status | (latch_eff & LATCH_LOW));

    vcrp_oam #(
        .DEPTH(SPRITE_MEM_DEPTH)
    ) u_oam (
        .i_clk  (i_clk),
        .i_we   (spr_we),
        .i_waddr(r_spr_addr[AW-1:0]),
        .i_wdata(wd),
        .i_re   (spr_re),
        .i_raddr(r_spr_addr[AW-1:0]),
        .o_rdata(spr_rdata)
    );

    // Next state and result for the beat at the input.
    always_comb begin
        n_ctrl_a    = r_ctrl_a;
        n_ctrl_b    = r_ctrl_b;
        n_status    = r_status;
        n_spr_addr  = r_spr_addr;
        n_toggle    = r_toggle;
        n_bus_latch = r_bus_latch;
        n_latch_mem = r_latch_mem;
        n_read_buf  = r_read_buf;
        n_step      = r_step;
        n_refresh   = r_refresh;
        n_vaddr     = r_vaddr;
        n_fine      = r_fine;
        n_out_mem   = 1'b0;
        n_out       = '0;
        spr_we      = 1'b0;
        spr_re      = 1'b0;
        unique case (i_data.req_type)
            REQ_CPU_READ: begin
                unique case (i_data.reg_index)
                    REG_STATUS: begin
                        n_bus_latch       = status_bl;
                        n_latch_mem       = 1'b0;
                        n_toggle          = 1'b0;
                        n_out.read_data   = status_bl;
                        if (status_bl[7]) begin
                            n_status = r_status & (ST_HIT | ST_OVER);
                        end
                    end
                    REG_OAM_DATA: begin
                        spr_re      = accept;
                        n_latch_mem = 1'b1;
                        n_out_mem   = 1'b1;
                    end
                    REG_DATA: begin
                        n_out.mem_read    = 1'b1;
                        n_out.mem_address = r_vaddr[13:0];
                        n_vaddr           = vaddr_inc;
                        if (r_vaddr[13:0] >= PALETTE_BASE) begin
                            n_out.read_data = i_data.ext_read_data;
                        end else begin
                            n_out.read_data = r_read_buf;
                            n_bus_latch     = r_read_buf;
                            n_latch_mem     = 1'b0;
                            n_read_buf      = i_data.ext_read_data;
                        end
                    end
                    default: begin
                        n_out.read_data = latch_eff;
                    end
                endcase
            end
            REQ_CPU_WRITE: begin
                n_bus_latch = wd;
                n_latch_mem = 1'b0;
                unique case (widx)
                    REG_CTRL0: begin
                        n_ctrl_a         = wd;
                        n_refresh[11:10] = wd[1:0];
                        n_step           = wd[2] ? STEP_DOWN : STEP_ACROSS;
                    end
                    REG_CTRL1: begin
                        n_ctrl_b = wd;
                    end
                    REG_OAM_ADDR: begin
                        n_spr_addr = wd;
                    end
                    REG_OAM_DATA: begin
                        spr_we     = accept;
                        n_spr_addr = r_spr_addr + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (r_toggle) begin
                            n_refresh[9:5]   = wd[7:3];
                            n_refresh[14:12] = wd[2:0];
                        end else begin
                            n_refresh[4:0] = wd[7:3];
                            n_fine         = wd[2:0];
                        end
                        n_toggle = !r_toggle;
                    end
                    REG_ADDR: begin
                        if (r_toggle) begin
                            n_refresh[7:0]        = wd;
                            n_vaddr               = {r_refresh[14:8], wd};
                            n_out.address_latched = 1'b1;
                        end else begin
                            n_refresh[14:8] = {1'b0, wd[5:0]};
                        end
                        n_toggle = !r_toggle;
                    end
                    REG_DATA: begin
                        n_out.mem_write      = 1'b1;
                        n_out.mem_address    = r_vaddr[13:0];
                        n_out.mem_write_data = wd;
                        n_vaddr              = vaddr_inc;
                    end
                    default: begin
                    end
                endcase
            end
            REQ_VBL_START: begin
                n_status = r_status | ST_VBLANK;
            end
            REQ_VBL_END: begin
                n_status = r_status & ~(ST_VBLANK | ST_HIT | ST_OVER);
            end
            REQ_RENDER_STAT: begin
                n_status = r_status | (i_data.status_flags[0] ? ST_HIT : 8'h00)
                                    | (i_data.status_flags[1] ? ST_OVER : 8'h00);
            end
            default: begin
            end
        endcase
        n_out.scroll_address = n_refresh;
        n_out.fine_x         = n_fine;
        n_out.control_zero   = n_ctrl_a;
        n_out.control_one    = n_ctrl_b;
        n_out.status_value   = n_status;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec <= '0;
        end else if (i_cfg_we) begin
            r_sec <= i_cfg_wdata;
        end
    end

    // Port state, updated when a beat is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_a    <= '0;
            r_ctrl_b    <= '0;
            r_status    <= '0;
            r_spr_addr  <= '0;
            r_toggle    <= 1'b0;
            r_bus_latch <= '0;
            r_latch_mem <= 1'b0;
            r_read_buf  <= '0;
            r_step      <= STEP_ACROSS;
            r_refresh   <= '0;
            r_vaddr     <= '0;
            r_fine      <= '0;
        end else if (accept) begin
            r_ctrl_a    <= n_ctrl_a;
            r_ctrl_b    <= n_ctrl_b;
            r_status    <= n_status;
            r_spr_addr  <= n_spr_addr;
            r_toggle    <= n_toggle;
            r_bus_latch <= n_bus_latch;
            r_latch_mem <= n_latch_mem;
            r_read_buf  <= n_read_buf;
            r_step      <= n_step;
            r_refresh   <= n_refresh;
            r_vaddr     <= n_vaddr;
            r_fine      <= n_fine;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_mem   <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
            r_out_mem   <= n_out_mem;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    // A sprite data read takes its byte from the memory read register.
    always_comb begin
        o_data = r_out;
        if (r_out_mem) begin
            o_data.read_data = spr_rdata;
        end
    end

    assign o_valid = r_out_valid;

endmodule

@@ design/vcrp_checker.sv @@
`timescale 1ns / 1ps

// Checks on what the port shows over time.
module vcrp_checker
    import vcrp_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_valid,
    input logic     i_stall,
    input t_req_out o_data
);

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result beat changed");

    // No result is offered right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat offered after reset");

    // A beat never reads and writes video memory at once.
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.mem_read && o_data.mem_write))
        else $error("memory read and write in one beat");

    // Write data appears only on a beat that writes video memory.
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.mem_write |-> o_data.mem_write_data == 8'd0)
        else $error("write data without a memory write");

    // Loading the VRAM address carries no memory access.
    a_latch_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.address_latched |->
            !o_data.mem_read && !o_data.mem_write && o_data.mem_address == 14'd0
            && o_data.read_data == 8'd0)
        else $error("address load beat carries an access");

endmodule

bind video_chip_register_port_top vcrp_checker u_vcrp_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_data (o_data)
);
